/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define WODSU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Checks that an expression never holds outside of reset.
`define WODSU_ASSERT_NEVER(lbl, expr) \
  `WODSU_ASSERT(lbl, !(expr))

`endif

/* hw/rtl/wodsu_pkg.sv */
// ----------------------------------------------------------------------------
// Wheel odometry package
// Widths, command and register codes, and divider constants shared by the
// odometry state and result stages.
// ----------------------------------------------------------------------------
package wodsu_pkg;

  // Field and register widths.
  localparam int CmdW    = 3;
  localparam int TimeW   = 32;
  localparam int IncW    = 16;
  localparam int ScaleW  = 10;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;
  localparam int AccW    = 32;
  localparam int DistW   = 26;
  localparam int SpeedW  = 24;

  // Speed history ring; the depth must be a power of two.
  localparam int AvgDepth = 4;
  localparam int SlotW    = $clog2(AvgDepth);
  localparam int SumW     = AccW + SlotW;

  // Product of a distance delta and the speed scale.
  localparam int TickW = AccW + 1 + ScaleW + 1;

  // Division by 25 as a reciprocal multiply, exact for 30-bit dividends.
  localparam int                    QuoInW      = AccW - 2;
  localparam int                    Div25MulW   = 31;
  localparam logic [Div25MulW-1:0]  Div25Mul    = 31'd1374389535;
  localparam int                    Div25Shift  = 35;
  localparam int                    ProdW       = QuoInW + Div25MulW;
  localparam int                    QW          = ProdW - Div25Shift;

  // Shift that takes the ring sum down to sum / (4 * AvgDepth).
  localparam int SpeedShift = SlotW + 2;

  // Saturation limits of the speed outputs, as magnitudes.
  localparam int SpeedPosLim = (1 << (SpeedW - 1)) - 1;
  localparam int SpeedNegLim = 1 << (SpeedW - 1);

  // Increment reset value and speed scale reset value.
  localparam logic [IncW-1:0]   IncReset   = 16'd212;
  localparam logic [ScaleW-1:0] ScaleReset = 10'd20;

  typedef enum logic [CmdW-1:0] {
    CmdLeftFirst   = 3'd0,
    CmdLeftSecond  = 3'd1,
    CmdRightFirst  = 3'd2,
    CmdRightSecond = 3'd3,
    CmdLeftCount   = 3'd4,
    CmdRightCount  = 3'd5,
    CmdTick        = 3'd6,
    CmdClear       = 3'd7
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLeftInc  = 2'd0,
    CfgRightInc = 2'd1,
    CfgScale    = 2'd2
  } cfg_idx_e;

  typedef logic [AccW-1:0] acc_t;

  // State as seen right after one item: both distances and both rings.
  typedef struct packed {
    acc_t [1:0]            acc;
    acc_t [2*AvgDepth-1:0] hist;
  } snap_t;

endpackage

/* hw/rtl/wodsu_state.sv */
// ----------------------------------------------------------------------------
// Wheel odometry state
// Input register, configuration registers and the odometry state: edge
// stamps, directions, distance accumulators and speed history rings.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wodsu_state (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [wodsu_pkg::CmdW-1:0]          command_i,
  input  logic [wodsu_pkg::TimeW-1:0]         event_time_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wodsu_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [wodsu_pkg::CfgW-1:0]          cfg_data_i,
  output logic                                snap_valid_o,
  input  logic                                snap_ready_i,
  output wodsu_pkg::snap_t                    snap_o
);
  import wodsu_pkg::*;

  // Configuration registers.
  logic [IncW-1:0]   left_inc_q, right_inc_q;
  logic [ScaleW-1:0] scale_q;

  // Input register and the stage that marks a finished state update.
  logic             v1_q, v1_d, v2_q, v2_d;
  cmd_e             cmd1_q;
  logic [TimeW-1:0] time1_q;
  logic             rdy1, rdy2, adv1, load1;

  // Odometry state.
  logic [TimeW-1:0] stamp_q [4];
  logic [TimeW-1:0] stamp_d [4];
  logic             lf_q, lf_d, rf_q, rf_d;
  acc_t             acc_q [2];
  acc_t             acc_d [2];
  acc_t             prev_q [2];
  acc_t             prev_d [2];
  acc_t             hist_q [2][AvgDepth];
  acc_t             hist_d [2][AvgDepth];
  logic [SlotW-1:0] slot_q, slot_d;

  logic       lf_new, rf_new;
  logic [1:0] stamp_idx;
  acc_t       left_step, right_step;
  acc_t       tick_val [2];

  // Adds or subtracts an increment and clips to the signed accumulator range.
  function automatic acc_t step_acc(acc_t acc, logic [IncW-1:0] inc, logic fwd);
    logic signed [AccW:0] a;
    logic signed [AccW:0] b;
    logic signed [AccW:0] s;
    a = $signed({acc[AccW-1], acc});
    b = $signed({1'b0, {(AccW-IncW){1'b0}}, inc});
    s = fwd ? (a + b) : (a - b);
    if (s[AccW] != s[AccW-1]) begin
      return s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end
    return s[AccW-1:0];
  endfunction

  // Scaled distance delta of one wheel, clipped to the signed accumulator range.
  function automatic acc_t tick_sample(acc_t acc, acc_t prev, logic [ScaleW-1:0] sc);
    logic signed [AccW:0]    d;
    logic signed [ScaleW:0]  m;
    logic signed [TickW-1:0] p;
    d = $signed({acc[AccW-1], acc}) - $signed({prev[AccW-1], prev});
    m = $signed({1'b0, sc});
    p = d * m;
    if (!((&p[TickW-1:AccW-1]) || !(|p[TickW-1:AccW-1]))) begin
      return p[TickW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end
    return p[AccW-1:0];
  endfunction

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_inc_q  <= IncReset;
      right_inc_q <= IncReset;
      scale_q     <= ScaleReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgLeftInc:  left_inc_q  <= cfg_data_i;
        CfgRightInc: right_inc_q <= cfg_data_i;
        CfgScale:    scale_q     <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake between the input register, the update stage and the results.
  assign rdy2       = !v2_q || snap_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign adv1       = v1_q && rdy2;
  assign load1      = in_valid_i && rdy1;
  assign in_stall_o = !rdy1;
  assign v1_d       = load1 || (v1_q && !rdy2);
  assign v2_d       = adv1 || (v2_q && !snap_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      cmd1_q  <= cmd_e'(command_i);
      time1_q <= event_time_i;
    end
  end

  // Direction decisions and the per-command candidate updates.
  assign lf_new      = stamp_q[0] < stamp_q[1];
  assign rf_new      = stamp_q[2] > stamp_q[3];
  assign stamp_idx   = 2'(cmd1_q);
  assign left_step   = step_acc(acc_q[0], left_inc_q, lf_new && rf_q);
  assign right_step  = step_acc(acc_q[1], right_inc_q, lf_q && rf_new);
  assign tick_val[0] = tick_sample(acc_q[0], prev_q[0], scale_q);
  assign tick_val[1] = tick_sample(acc_q[1], prev_q[1], scale_q);

  // Next state of the odometry for the item leaving the input register.
  always_comb begin
    stamp_d = stamp_q;
    lf_d    = lf_q;
    rf_d    = rf_q;
    acc_d   = acc_q;
    prev_d  = prev_q;
    hist_d  = hist_q;
    slot_d  = slot_q;
    if (adv1) begin
      unique case (cmd1_q)
        CmdLeftFirst, CmdLeftSecond, CmdRightFirst, CmdRightSecond: begin
          stamp_d[stamp_idx] = time1_q;
        end
        CmdLeftCount: begin
          lf_d     = lf_new;
          acc_d[0] = left_step;
        end
        CmdRightCount: begin
          rf_d     = rf_new;
          acc_d[1] = right_step;
        end
        CmdTick: begin
          hist_d[0][slot_q] = tick_val[0];
          hist_d[1][slot_q] = tick_val[1];
          prev_d            = acc_q;
          slot_d            = slot_q + 1'b1;
        end
        CmdClear: begin
          acc_d[0] = '0;
          acc_d[1] = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= '{default: '0};
      lf_q    <= 1'b1;
      rf_q    <= 1'b1;
      acc_q   <= '{default: '0};
      prev_q  <= '{default: '0};
      hist_q  <= '{default: '{default: '0}};
      slot_q  <= '0;
    end else begin
      stamp_q <= stamp_d;
      lf_q    <= lf_d;
      rf_q    <= rf_d;
      acc_q   <= acc_d;
      prev_q  <= prev_d;
      hist_q  <= hist_d;
      slot_q  <= slot_d;
    end
  end

  // The state registers hold the snapshot while the update stage waits.
  assign snap_valid_o = v2_q;
  always_comb begin
    snap_o.acc[0] = acc_q[0];
    snap_o.acc[1] = acc_q[1];
    for (int i = 0; i < AvgDepth; i++) begin
      snap_o.hist[i]            = hist_q[0][i];
      snap_o.hist[AvgDepth + i] = hist_q[1][i];
    end
  end

  `WODSU_ASSERT(a_clear_zeroes,
    (adv1 && cmd1_q == CmdClear) |=> (acc_q[0] == '0 && acc_q[1] == '0))
  `WODSU_ASSERT(a_slot_only_on_tick,
    (adv1 && cmd1_q != CmdTick) |=> $stable(slot_q))
  `WODSU_ASSERT(a_prev_follows_tick,
    (adv1 && cmd1_q == CmdTick) |=>
      (prev_q[0] == $past(acc_q[0]) && prev_q[1] == $past(acc_q[1])))

endmodule

/* hw/rtl/wodsu_result.sv */
// ----------------------------------------------------------------------------
// Wheel odometry result stages
// Converts a state snapshot into distances in cm and average speeds in cm/s
// through a four-stage pipeline ending in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wodsu_result (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              snap_valid_i,
  output logic                              snap_ready_o,
  input  wodsu_pkg::snap_t                  snap_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [wodsu_pkg::DistW-1:0]       left_distance_cm_o,
  output logic [wodsu_pkg::DistW-1:0]       right_distance_cm_o,
  output logic [wodsu_pkg::SpeedW-1:0]      left_speed_cms_o,
  output logic [wodsu_pkg::SpeedW-1:0]      right_speed_cms_o
);
  import wodsu_pkg::*;

  logic v3_q, v4_q, v5_q, v6_q;
  logic rdy3, rdy4, rdy5, rdy6;
  logic load3, load4, load5, load6;

  // Stage 3: distance magnitudes and ring sums.
  logic [AccW-1:0] dmag3_q [2];
  logic            dneg3_q [2];
  logic [SumW-1:0] ssum3_q [2];
  logic [AccW-1:0] dmag3_d [2];
  logic [SumW-1:0] ssum3_d [2];

  // Stage 4: distance quotients and speed magnitudes.
  logic [QW-1:0]   dq4_q [2];
  logic            dneg4_q [2];
  logic [SumW-1:0] smag4_q [2];
  logic            sneg4_q [2];
  logic [ProdW-1:0] dprod [2];

  // Stage 5: signed distances and speed quotients.
  logic [DistW-1:0] dist5_q [2];
  logic [QW-1:0]    sq5_q [2];
  logic             sneg5_q [2];
  logic [ProdW-1:0] sprod [2];

  // Stage 6: output register.
  logic [DistW-1:0]  dist6_q [2];
  logic [SpeedW-1:0] spd6_q [2];
  logic [SpeedW-1:0] spd6_d [2];
  logic [QW-1:0]     sneg_val [2];

  // Pipeline handshake: a stage loads when it is empty or drains.
  assign rdy6  = !v6_q || !out_stall_i;
  assign rdy5  = !v5_q || rdy6;
  assign rdy4  = !v4_q || rdy5;
  assign rdy3  = !v3_q || rdy4;
  assign load3 = snap_valid_i && rdy3;
  assign load4 = v3_q && rdy4;
  assign load5 = v4_q && rdy5;
  assign load6 = v5_q && rdy6;
  assign snap_ready_o = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v3_q <= load3 || (v3_q && !rdy4);
      v4_q <= load4 || (v4_q && !rdy5);
      v5_q <= load5 || (v5_q && !rdy6);
      v6_q <= load6 || (v6_q && out_stall_i);
    end
  end

  // Absolute distances and the sum of each wheel's ring.
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      dmag3_d[w] = snap_i.acc[w][AccW-1] ? (AccW'(0) - snap_i.acc[w]) : snap_i.acc[w];
      ssum3_d[w] = '0;
      for (int i = 0; i < AvgDepth; i++) begin
        ssum3_d[w] = ssum3_d[w] + SumW'($signed(snap_i.hist[w*AvgDepth + i]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load3) begin
      for (int w = 0; w < 2; w++) begin
        dmag3_q[w] <= dmag3_d[w];
        dneg3_q[w] <= snap_i.acc[w][AccW-1];
        ssum3_q[w] <= ssum3_d[w];
      end
    end
  end

  // Distance / 100 as (magnitude / 4) / 25; speed sum magnitude.
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      dprod[w] = ProdW'(dmag3_q[w][AccW-1:2]) * ProdW'(Div25Mul);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load4) begin
      for (int w = 0; w < 2; w++) begin
        dq4_q[w]   <= dprod[w][ProdW-1:Div25Shift];
        dneg4_q[w] <= dneg3_q[w];
        smag4_q[w] <= ssum3_q[w][SumW-1] ? (SumW'(0) - ssum3_q[w]) : ssum3_q[w];
        sneg4_q[w] <= ssum3_q[w][SumW-1];
      end
    end
  end

  // Signed distances; speed magnitude / (4 * AvgDepth) then / 25.
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      sprod[w] = ProdW'(smag4_q[w][SumW-1:SpeedShift]) * ProdW'(Div25Mul);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load5) begin
      for (int w = 0; w < 2; w++) begin
        dist5_q[w] <= dneg4_q[w] ? DistW'(QW'(0) - dq4_q[w]) : DistW'(dq4_q[w]);
        sq5_q[w]   <= sprod[w][ProdW-1:Div25Shift];
        sneg5_q[w] <= sneg4_q[w];
      end
    end
  end

  // Speed sign and saturation to the output range.
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      sneg_val[w] = QW'(0) - sq5_q[w];
      if (!sneg5_q[w]) begin
        spd6_d[w] = (sq5_q[w] > QW'(SpeedPosLim)) ? {1'b0, {(SpeedW-1){1'b1}}}
                                                  : SpeedW'(sq5_q[w]);
      end else begin
        spd6_d[w] = (sq5_q[w] > QW'(SpeedNegLim)) ? {1'b1, {(SpeedW-1){1'b0}}}
                                                  : SpeedW'(sneg_val[w]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load6) begin
      dist6_q <= dist5_q;
      spd6_q  <= spd6_d;
    end
  end

  assign out_valid_o         = v6_q;
  assign left_distance_cm_o  = dist6_q[0];
  assign right_distance_cm_o = dist6_q[1];
  assign left_speed_cms_o    = spd6_q[0];
  assign right_speed_cms_o   = spd6_q[1];

  `WODSU_ASSERT(a_stage3_holds,
    (v3_q && !rdy4) |=> (v3_q && $stable(dmag3_q[0]) && $stable(ssum3_q[1])))

endmodule

/* hw/rtl/wheel_odometry_direction_speed_unit.sv */
// ----------------------------------------------------------------------------
// Wheel odometry with direction sensing and moving-average speed
// Top level: input register and odometry state followed by the result stages.
// ----------------------------------------------------------------------------
// The unit takes one sensor event per clock cycle when not stalled and returns
// one result item per event, in order. Each event updates the odometry state
// as it leaves the input register for the update stage; four further stages
// divide the distances by 100 and the four-sample speed sums by 400 through
// reciprocal multiplies, placed between stages 3 and 4 for the distances and
// between stages 4 and 5 for the speeds. A stall on the output backs up
// through the pipeline and reaches the input only once every stage is full.
// Configuration writes are always accepted and take effect for the next event.
module wheel_odometry_direction_speed_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [wodsu_pkg::CmdW-1:0]        command_i,
  input  logic [wodsu_pkg::TimeW-1:0]       event_time_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [wodsu_pkg::DistW-1:0]       left_distance_cm_o,
  output logic [wodsu_pkg::DistW-1:0]       right_distance_cm_o,
  output logic [wodsu_pkg::SpeedW-1:0]      left_speed_cms_o,
  output logic [wodsu_pkg::SpeedW-1:0]      right_speed_cms_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wodsu_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [wodsu_pkg::CfgW-1:0]        cfg_data_i
);
  import wodsu_pkg::*;

  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  // Odometry state and its update.
  wodsu_state u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .event_time_i (event_time_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  // Unit conversion and averaging.
  wodsu_result u_result (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .snap_valid_i        (snap_valid),
    .snap_ready_o        (snap_ready),
    .snap_i              (snap),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .left_distance_cm_o  (left_distance_cm_o),
    .right_distance_cm_o (right_distance_cm_o),
    .left_speed_cms_o    (left_speed_cms_o),
    .right_speed_cms_o   (right_speed_cms_o)
  );

endmodule
